// ===== rtl/assert_macros.svh =====
// assertion helpers for the grid peak finder
// used by the top level, no other dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/glmf_pkg.sv =====
// shared constants and types for the grid peak finder
// no dependencies
`timescale 1ns / 1ps

package glmf_pkg;

  // parameter defaults
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int MAX_COLS_DEF    = 32;
  localparam int MAX_ROWS_DEF    = 64;

  // configuration port
  localparam int ROWS_CFG_W = 7;
  localparam int COLS_CFG_W = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 2'd1;

  localparam logic [ROWS_CFG_W-1:0] GRID_ROWS_RST = 7'd20;
  localparam logic [COLS_CFG_W-1:0] GRID_COLS_RST = 6'd20;

  // result fields
  localparam int ROW_OUT_W = 6;
  localparam int COL_OUT_W = 5;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_UP,
    ST_RD_SIDE,
    ST_RD_ROW,
    ST_EVAL,
    ST_FLUSH,
    ST_MARK
  } state_t;

  // line store read groups
  typedef enum logic [1:0] {
    RD_UP,
    RD_SIDE,
    RD_ROW
  } rd_sel_t;

  // controller to datapath
  typedef struct packed {
    logic    take;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    cap_up;
    logic    cap_side;
    logic    eval;
    logic    load_peak;
    logic    scan_clr;
    logic    scan_adv;
    logic    load_flag;
    logic    load_mark;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic above_peak;
    logic grid_end;
    logic out_free;
    logic flags_none;
    logic flag_hit;
    logic flag_final;
  } sts_t;

endpackage

// ===== rtl/glmf_if.sv =====
// valid/ready channels for the grid peak finder: samples in, peaks out
// depends on glmf_pkg
`timescale 1ns / 1ps

interface glmf_in_if #(
  parameter int SAMPLE_BITS = glmf_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] elevation;

  modport source (output valid, output elevation, input ready);
  modport sink   (input valid, input elevation, output ready);
endinterface

interface glmf_out_if;
  logic                              valid;
  logic                              ready;
  logic [glmf_pkg::ROW_OUT_W-1:0]    peak_row;
  logic [glmf_pkg::COL_OUT_W-1:0]    peak_col;
  logic                              peak_found;
  logic                              frame_last;

  modport source (output valid, output peak_row, output peak_col,
                  output peak_found, output frame_last, input ready);
  modport sink   (input valid, input peak_row, input peak_col,
                  input peak_found, input frame_last, output ready);
endinterface

// ===== rtl/glmf_ctrl.sv =====
// sequencer for the grid peak finder: accept, three line store reads,
// decide, last-row flush; depends on glmf_pkg
`timescale 1ns / 1ps

module glmf_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  glmf_pkg::sts_t sts,
  output glmf_pkg::cmd_t cmd
);

  glmf_pkg::state_t state_r;
  glmf_pkg::state_t state_nxt;

  logic eval_go;

  // decision may leave once a pending peak can be loaded
  assign eval_go = !sts.above_peak || sts.out_free;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= glmf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      glmf_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = glmf_pkg::ST_RD_UP;
      end
      glmf_pkg::ST_RD_UP:   state_nxt = glmf_pkg::ST_RD_SIDE;
      glmf_pkg::ST_RD_SIDE: state_nxt = glmf_pkg::ST_RD_ROW;
      glmf_pkg::ST_RD_ROW:  state_nxt = glmf_pkg::ST_EVAL;
      glmf_pkg::ST_EVAL: begin
        if (eval_go) begin
          state_nxt = sts.grid_end ? glmf_pkg::ST_FLUSH : glmf_pkg::ST_IDLE;
        end
      end
      glmf_pkg::ST_FLUSH: begin
        if (sts.flags_none) begin
          state_nxt = glmf_pkg::ST_MARK;
        end else if (sts.flag_hit && sts.out_free && sts.flag_final) begin
          state_nxt = glmf_pkg::ST_IDLE;
        end
      end
      glmf_pkg::ST_MARK: begin
        if (sts.out_free) state_nxt = glmf_pkg::ST_IDLE;
      end
      default: state_nxt = glmf_pkg::ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    cmd.rd_sel = glmf_pkg::RD_UP;
    unique case (state_r)
      glmf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      glmf_pkg::ST_RD_UP: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = glmf_pkg::RD_UP;
      end
      glmf_pkg::ST_RD_SIDE: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = glmf_pkg::RD_SIDE;
        cmd.cap_up = 1'b1;
      end
      glmf_pkg::ST_RD_ROW: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_sel   = glmf_pkg::RD_ROW;
        cmd.cap_side = 1'b1;
      end
      glmf_pkg::ST_EVAL: begin
        if (eval_go) begin
          cmd.eval      = 1'b1;
          cmd.load_peak = sts.above_peak;
          cmd.scan_clr  = sts.grid_end;
        end
      end
      glmf_pkg::ST_FLUSH: begin
        if (!sts.flags_none) begin
          if (sts.flag_hit) begin
            cmd.load_flag = sts.out_free;
            cmd.scan_adv  = sts.out_free;
          end else begin
            cmd.scan_adv = 1'b1;
          end
        end
      end
      glmf_pkg::ST_MARK: begin
        cmd.load_mark = sts.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/glmf_dpath.sv =====
// datapath for the grid peak finder: config registers, raster counters,
// three-row line store, neighbour compares, last-row flags, result register
// depends on glmf_pkg
`timescale 1ns / 1ps

module glmf_dpath #(
  parameter int MAX_COLS    = glmf_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS    = glmf_pkg::MAX_ROWS_DEF,
  parameter int SAMPLE_BITS = glmf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [glmf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [glmf_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic signed [SAMPLE_BITS-1:0]       in_elevation,
  input  glmf_pkg::cmd_t                      cmd,
  output glmf_pkg::sts_t                      sts,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [glmf_pkg::ROW_OUT_W-1:0]      out_peak_row,
  output logic [glmf_pkg::COL_OUT_W-1:0]      out_peak_col,
  output logic                                out_peak_found,
  output logic                                out_frame_last
);

  localparam int RCW    = glmf_pkg::ROWS_CFG_W;
  localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int CNT_W  = $clog2(MAX_COLS + 1);
  localparam int ROW_W  = (MAX_ROWS > 64) ? RCW : ((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1);
  localparam int DEPTH  = 3 * MAX_COLS;
  localparam int ADDR_W = $clog2(DEPTH);

  // configuration and counters
  logic [RCW-1:0]                   grid_rows_r;
  logic [glmf_pkg::COLS_CFG_W-1:0]  grid_cols_r;
  logic [RCW-1:0]                   rows_eff;
  logic [CNT_W-1:0]                 cols_eff;
  logic [ROW_W-1:0]                 row_r;
  logic [COL_W-1:0]                 col_r;
  logic [1:0]                       slot_r;
  logic                             restart;

  // line store and captured samples
  logic signed [SAMPLE_BITS-1:0] line_store_r [DEPTH];
  logic signed [SAMPLE_BITS-1:0] q0_r, q1_r;
  logic signed [SAMPLE_BITS-1:0] sample_r;
  logic signed [SAMPLE_BITS-1:0] ctr_r, up_r, left_r, right_r;
  logic [ADDR_W-1:0]             ra0, ra1, wa;
  logic [1:0]                    slot_up1, slot_up2;
  logic [COL_W-1:0]              col_m1, col_m2, col_p1;

  // flags and flush scan
  logic [MAX_COLS-1:0] flags_r;
  logic [MAX_COLS-1:0] flags_nxt;
  logic [MAX_COLS-1:0] flags_rest;
  logic [COL_W-1:0]    scan_r;

  // result register
  logic                           out_valid_r;
  logic [glmf_pkg::ROW_OUT_W-1:0] peak_row_r;
  logic [glmf_pkg::COL_OUT_W-1:0] peak_col_r;
  logic                           peak_found_r;
  logic                           frame_last_r;

  logic row_nz, row_ge2, col_nz, col_ge2, at_last_row, at_last_col;
  logic above_peak, flag_prev, flag_cur;

  function automatic logic [ADDR_W-1:0] mem_addr(input logic [1:0] slot,
                                                 input logic [COL_W-1:0] col);
    mem_addr = ADDR_W'(slot) * ADDR_W'(MAX_COLS) + ADDR_W'(col);
  endfunction

  // clamp out-of-range settings
  always_comb begin
    if (grid_rows_r == '0) begin
      rows_eff = RCW'(1);
    end else if (32'(grid_rows_r) > MAX_ROWS) begin
      rows_eff = RCW'(MAX_ROWS);
    end else begin
      rows_eff = grid_rows_r;
    end
    if (grid_cols_r == '0) begin
      cols_eff = CNT_W'(1);
    end else if (32'(grid_cols_r) > MAX_COLS) begin
      cols_eff = CNT_W'(MAX_COLS);
    end else begin
      cols_eff = CNT_W'(grid_cols_r);
    end
  end

  // position decode
  assign row_nz      = (row_r != '0);
  assign row_ge2     = (row_r > ROW_W'(1));
  assign col_nz      = (col_r != '0);
  assign col_ge2     = (col_r > COL_W'(1));
  assign at_last_row = (RCW'(row_r) == rows_eff - RCW'(1));
  assign at_last_col = (CNT_W'(col_r) == cols_eff - CNT_W'(1));

  assign restart = cfg_we && ((cfg_index == glmf_pkg::CFG_GRID_ROWS) ||
                              (cfg_index == glmf_pkg::CFG_GRID_COLS));

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_rows_r <= glmf_pkg::GRID_ROWS_RST;
      grid_cols_r <= glmf_pkg::GRID_COLS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        glmf_pkg::CFG_GRID_ROWS: grid_rows_r <= cfg_wdata;
        glmf_pkg::CFG_GRID_COLS: grid_cols_r <= cfg_wdata[glmf_pkg::COLS_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // raster counters, advanced once per sample, cleared at grid end
  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      row_r  <= '0;
      col_r  <= '0;
      slot_r <= '0;
    end else if (cmd.eval) begin
      if (at_last_row && at_last_col) begin
        row_r  <= '0;
        col_r  <= '0;
        slot_r <= '0;
      end else if (at_last_col) begin
        col_r  <= '0;
        row_r  <= row_r + ROW_W'(1);
        slot_r <= (slot_r == 2'd2) ? 2'd0 : slot_r + 2'd1;
      end else begin
        col_r <= col_r + COL_W'(1);
      end
    end
  end

  // read addresses: current row and row r-1 and r-2 slots, clamped neighbour columns
  assign slot_up1 = (slot_r == 2'd0) ? 2'd2 : slot_r - 2'd1;
  assign slot_up2 = (slot_r == 2'd2) ? 2'd0 : slot_r + 2'd1;
  assign col_m1   = col_nz ? col_r - COL_W'(1) : col_r;
  assign col_m2   = col_ge2 ? col_r - COL_W'(2) : col_r;
  assign col_p1   = at_last_col ? col_r : col_r + COL_W'(1);
  assign wa       = mem_addr(slot_r, col_r);

  always_comb begin
    unique case (cmd.rd_sel)
      glmf_pkg::RD_UP: begin
        ra0 = mem_addr(slot_up1, col_r);
        ra1 = mem_addr(slot_up2, col_r);
      end
      glmf_pkg::RD_SIDE: begin
        ra0 = mem_addr(slot_up1, col_m1);
        ra1 = mem_addr(slot_up1, col_p1);
      end
      glmf_pkg::RD_ROW: begin
        ra0 = mem_addr(slot_r, col_m1);
        ra1 = mem_addr(slot_r, col_m2);
      end
      default: begin
        ra0 = wa;
        ra1 = wa;
      end
    endcase
  end

  // line store, every entry whose value is used is written earlier in the same grid
  always_ff @(posedge clk) begin
    if (cmd.take) line_store_r[wa] <= in_elevation;
    if (cmd.rd_en) begin
      q0_r <= line_store_r[ra0];
      q1_r <= line_store_r[ra1];
    end
  end

  // sample and neighbour capture
  always_ff @(posedge clk) begin
    if (cmd.take) sample_r <= in_elevation;
    if (cmd.cap_up) begin
      ctr_r <= q0_r;
      up_r  <= q1_r;
    end
    if (cmd.cap_side) begin
      left_r  <= q0_r;
      right_r <= q1_r;
    end
  end

  // cell above: up, down, left, right; q regs hold the current row now
  assign above_peak = row_nz
                   && !(row_ge2 && (up_r > ctr_r))
                   && !(sample_r > ctr_r)
                   && !(col_nz && (left_r > ctr_r))
                   && !(!at_last_col && (right_r > ctr_r));

  // last row: left cell now has its right neighbour
  assign flag_prev = !(row_nz && (left_r > q0_r))
                  && !(col_ge2 && (q1_r > q0_r))
                  && !(sample_r > q0_r);

  // last cell of the grid
  assign flag_cur = !(row_nz && (ctr_r > sample_r))
                 && !(col_nz && (q0_r > sample_r));

  // last-row peak flags other than the column under scan
  always_comb begin
    flags_rest         = flags_r;
    flags_rest[scan_r] = 1'b0;
  end

  // last-row decisions in, flushed flags out
  always_comb begin
    flags_nxt = flags_r;
    if (cmd.eval && at_last_row) begin
      if (col_nz) flags_nxt[col_m1] = flag_prev;
      if (at_last_col) flags_nxt[col_r] = flag_cur;
    end
    if (cmd.load_flag) flags_nxt[scan_r] = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      flags_r <= '0;
      scan_r  <= '0;
    end else begin
      flags_r <= flags_nxt;
      if (cmd.scan_clr) begin
        scan_r <= '0;
      end else if (cmd.scan_adv) begin
        scan_r <= scan_r + COL_W'(1);
      end
    end
  end

  // result register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_peak || cmd.load_flag || cmd.load_mark) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.load_peak) begin
      peak_row_r   <= glmf_pkg::ROW_OUT_W'(row_r - ROW_W'(1));
      peak_col_r   <= glmf_pkg::COL_OUT_W'(col_r);
      peak_found_r <= 1'b1;
      frame_last_r <= 1'b0;
    end else if (cmd.load_flag) begin
      peak_row_r   <= glmf_pkg::ROW_OUT_W'(rows_eff - RCW'(1));
      peak_col_r   <= glmf_pkg::COL_OUT_W'(scan_r);
      peak_found_r <= 1'b1;
      frame_last_r <= (flags_rest == '0);
    end else if (cmd.load_mark) begin
      peak_row_r   <= '0;
      peak_col_r   <= '0;
      peak_found_r <= 1'b0;
      frame_last_r <= 1'b1;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_peak_row   = peak_row_r;
  assign out_peak_col   = peak_col_r;
  assign out_peak_found = peak_found_r;
  assign out_frame_last = frame_last_r;

  // status
  assign sts.above_peak = above_peak;
  assign sts.grid_end   = at_last_row && at_last_col;
  assign sts.out_free   = !out_valid_r || out_ready;
  assign sts.flags_none = (flags_r == '0);
  assign sts.flag_hit   = flags_r[scan_r];
  assign sts.flag_final = (flags_rest == '0);

endmodule

// ===== rtl/grid_local_maxima_finder.sv =====
// Grid peak finder, top level.
// Samples enter on in_ch (signed elevation, raster order, grid_rows by
// grid_cols set through the cfg write port, index 0 rows, 1 columns).
// A cell whose in-grid up, down, left and right neighbours are all not
// higher is reported on out_ch as row and column, in raster order.
// Each sample passes the accept, three two-port reads from the three-row
// line store and a decision step, held while a peak waits for out_ch; the
// next sample is accepted right after, or after the flush at grid end. A
// peak of the row above is valid on out_ch the cycle after its decision.
// After the last sample of a grid the last-row flags are scanned one
// column per cycle, a flagged one only while out_ch is free; each
// flagged column gives one beat, and the final beat carries frame_last.
// If no flag is set, one end marker beat follows (peak_found low,
// frame_last high). A config write restarts the grid. One result beat
// waits in the output register; while out_ch stalls the block still runs
// until it has a second result, then holds. Reset (synchronous, rst_n
// low) clears counters, flags, the output valid and loads 20 rows by 20
// columns. No line store clearing: a grid uses only entries it wrote.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module grid_local_maxima_finder #(
  parameter int MAX_COLS    = glmf_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS    = glmf_pkg::MAX_ROWS_DEF,
  parameter int SAMPLE_BITS = glmf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  glmf_in_if.sink                          in_ch,
  glmf_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [glmf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [glmf_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  glmf_pkg::cmd_t cmd;
  glmf_pkg::sts_t sts;
  logic signed [SAMPLE_BITS-1:0] in_sample;

  assign in_sample = in_ch.elevation;

  // sequencer
  glmf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath
  glmf_dpath #(
    .MAX_COLS    (MAX_COLS),
    .MAX_ROWS    (MAX_ROWS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_elevation   (in_sample),
    .cmd            (cmd),
    .sts            (sts),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .out_peak_row   (out_ch.peak_row),
    .out_peak_col   (out_ch.peak_col),
    .out_peak_found (out_ch.peak_found),
    .out_frame_last (out_ch.frame_last)
  );

  // a result is never loaded over a beat that is still waiting
  `ASSERT_IMPL(a_load_when_free, clk, rst_n, cmd.load_peak || cmd.load_flag || cmd.load_mark, sts.out_free)

  // no input beat is taken while a result is being loaded
  `ASSERT_IMPL(a_take_not_loading, clk, rst_n, in_ch.valid && in_ch.ready, !(cmd.load_peak || cmd.load_flag || cmd.load_mark))

  // an accepted beat starts the read sequence in the next cycle
  `ASSERT_NEXT(a_read_follows_take, clk, rst_n, in_ch.valid && in_ch.ready, cmd.rd_en && (cmd.rd_sel == glmf_pkg::RD_UP))

  // an end marker is the last beat of a grid and reports position zero
  `ASSERT_IMPL(a_marker_form, clk, rst_n, out_ch.valid && !out_ch.peak_found, out_ch.frame_last && (out_ch.peak_row == '0) && (out_ch.peak_col == '0))

endmodule

// ===== verif/tb_grid_local_maxima_finder.sv =====
// self-checking testbench for grid_local_maxima_finder: streams elevation grids
// and compares every peak beat with an in-bench prediction of the peak search
// depends on glmf_pkg, glmf_if and the rtl top level
`timescale 1ns / 1ps

module tb_grid_local_maxima_finder;

  localparam int IDLE_PCT     = 6;
  localparam int SETTLE       = 20;
  localparam int TAIL         = 40;
  localparam int RANDOM_ITEMS = 310;
  localparam int CYCLE_LIMIT  = 300000;

  localparam int SAMPLE_W = glmf_pkg::SAMPLE_BITS_DEF;
  localparam int COLS_MAX = glmf_pkg::MAX_COLS_DEF;
  localparam int ROWS_MAX = glmf_pkg::MAX_ROWS_DEF;

  // indexes past the register list, writes to them are dropped
  localparam logic [glmf_pkg::CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [glmf_pkg::CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  typedef enum int {FILL_FULL, FILL_NARROW, FILL_EDGES} fill_t;

  typedef struct packed {
    logic [glmf_pkg::ROW_OUT_W-1:0] peak_row;
    logic [glmf_pkg::COL_OUT_W-1:0] peak_col;
    logic                           peak_found;
    logic                           frame_last;
  } peak_beat_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                            cfg_we;
  logic [glmf_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [glmf_pkg::CFG_DATA_W-1:0] cfg_wdata;

  glmf_in_if #(.SAMPLE_BITS(SAMPLE_W)) in_ch ();
  glmf_out_if out_ch ();

  grid_local_maxima_finder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predicted peak search state
  logic signed [SAMPLE_W-1:0]          row_buf [3][COLS_MAX];
  bit                                  last_row_peak [COLS_MAX];
  int                                  next_row;
  int                                  next_col;
  logic [glmf_pkg::ROWS_CFG_W-1:0]     rows_setting = glmf_pkg::GRID_ROWS_RST;
  logic [glmf_pkg::COLS_CFG_W-1:0]     cols_setting = glmf_pkg::GRID_COLS_RST;

  peak_beat_t expected_peaks[$];
  int         fail_count;
  int         cycle_count;
  bit         no_idle;

  function automatic int rows_in_use();
    if (rows_setting == 0) return 1;
    if (rows_setting > ROWS_MAX) return ROWS_MAX;
    return rows_setting;
  endfunction

  function automatic int cols_in_use();
    if (cols_setting == 0) return 1;
    if (cols_setting > COLS_MAX) return COLS_MAX;
    return cols_setting;
  endfunction

  function automatic void restart_grid();
    foreach (last_row_peak[k]) last_row_peak[k] = 1'b0;
    next_row = 0;
    next_col = 0;
  endfunction

  // append one beat to the expected list
  function automatic void expect_beat(peak_beat_t b);
    expected_peaks = {expected_peaks, b};
  endfunction

  // no in-grid four-neighbor strictly higher
  function automatic bit cell_is_peak(int r, int c, bit has_down, int cols);
    logic signed [SAMPLE_W-1:0] v;
    v = row_buf[r % 3][c];
    if (r >= 1 && row_buf[(r + 2) % 3][c] > v) return 1'b0;
    if (has_down && row_buf[(r + 1) % 3][c] > v) return 1'b0;
    if (c >= 1 && row_buf[r % 3][c - 1] > v) return 1'b0;
    if (c + 1 < cols && row_buf[r % 3][c + 1] > v) return 1'b0;
    return 1'b1;
  endfunction

  function automatic peak_beat_t make_beat(int r, int c, bit found, bit last_flag);
    peak_beat_t b;
    b.peak_row   = glmf_pkg::ROW_OUT_W'(r);
    b.peak_col   = glmf_pkg::COL_OUT_W'(c);
    b.peak_found = found;
    b.frame_last = last_flag;
    return b;
  endfunction

  // peaks caused by one accepted sample
  task automatic predict_peaks(input logic signed [SAMPLE_W-1:0] elev);
    int rows, cols, r, c, k;
    bit held;
    peak_beat_t pend;
    rows = rows_in_use();
    cols = cols_in_use();
    if (next_row >= rows || next_col >= cols) restart_grid();
    r = next_row;
    c = next_col;
    row_buf[r % 3][c] = elev;
    // decision for the cell above
    if (r >= 1 && cell_is_peak(r - 1, c, 1'b1, cols))
      expect_beat(make_beat(r - 1, c, 1'b1, 1'b0));
    // last row kept as flags until the grid ends
    if (r == rows - 1 && c >= 1)
      last_row_peak[c - 1] = cell_is_peak(r, c - 1, 1'b0, cols);
    if (r == rows - 1 && c == cols - 1) begin
      last_row_peak[c] = cell_is_peak(r, c, 1'b0, cols);
      held = 1'b0;
      for (k = 0; k < cols; k++) begin
        if (last_row_peak[k]) begin
          if (held) expect_beat(pend);
          pend = make_beat(r, k, 1'b1, 1'b0);
          held = 1'b1;
        end
      end
      // empty flush gives the end marker
      if (!held) pend = make_beat(0, 0, 1'b0, 1'b0);
      pend.frame_last = 1'b1;
      expect_beat(pend);
      restart_grid();
    end else begin
      c++;
      if (c >= cols) begin
        c = 0;
        r++;
      end
      next_row = r;
      next_col = c;
    end
  endtask

  function automatic logic signed [SAMPLE_W-1:0] random_elev(fill_t fill);
    case (fill)
      FILL_NARROW: return SAMPLE_W'($urandom_range(0, 3) - 2);
      FILL_EDGES: begin
        case ($urandom_range(0, 3))
          0: return 16'sh7FFF;
          1: return 16'sh8000;
          2: return 16'sh0000;
          default: return 16'shFFFF;
        endcase
      end
      default: return SAMPLE_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // one sample beat, predicted at the accepting edge
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] elev);
    if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.elevation <= elev;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    predict_peaks(elev);
  endtask

  // drop valid, wait for all peaks, then let the pipeline settle
  task automatic wait_idle(input int settle_cycles);
    in_ch.valid <= 1'b0;
    while (expected_peaks.size() != 0) @(posedge clk);
    repeat (settle_cycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [glmf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [glmf_pkg::CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      glmf_pkg::CFG_GRID_ROWS: begin
        rows_setting = value[glmf_pkg::ROWS_CFG_W-1:0];
        restart_grid();
      end
      glmf_pkg::CFG_GRID_COLS: begin
        cols_setting = value[glmf_pkg::COLS_CFG_W-1:0];
        restart_grid();
      end
      default: ;
    endcase
  endtask

  // one row at reset width, alternating extremes: peaks on even columns
  task automatic test_default_width();
    int c;
    write_reg(glmf_pkg::CFG_GRID_ROWS, 7'd1);
    for (c = 0; c < 20; c++) send_sample(c % 2 == 0 ? 16'sh7FFF : 16'sh8000);
    wait_idle(SETTLE);
  endtask

  // zero sizes act as one cell, each sample is a whole grid
  task automatic test_single_cell();
    write_reg(glmf_pkg::CFG_GRID_ROWS, 7'd0);
    write_reg(glmf_pkg::CFG_GRID_COLS, 7'd0);
    send_sample(16'sh8000);
    send_sample(16'sh0000);
    wait_idle(SETTLE);
  endtask

  // flat grid, every cell is a peak
  task automatic test_plateau();
    int k;
    write_reg(glmf_pkg::CFG_GRID_ROWS, 7'd2);
    write_reg(glmf_pkg::CFG_GRID_COLS, 7'd3);
    for (k = 0; k < 6; k++) send_sample(16'shFFFF);
    wait_idle(SETTLE);
  endtask

  // low last row, flush finds nothing and sends the end marker
  task automatic test_end_marker();
    write_reg(glmf_pkg::CFG_GRID_COLS, 7'd2);
    send_sample(16'sd5);
    send_sample(16'sd5);
    send_sample(-16'sd5);
    send_sample(-16'sd5);
    wait_idle(SETTLE);
  endtask

  // spare index leaves the grid alone, a real write restarts it
  task automatic test_restart_on_write();
    int k;
    for (k = 0; k < 3; k++) send_sample(random_elev(FILL_NARROW));
    wait_idle(SETTLE);
    write_reg(CFG_SPARE_2, glmf_pkg::CFG_DATA_W'($urandom));
    write_reg(CFG_SPARE_3, glmf_pkg::CFG_DATA_W'($urandom));
    send_sample(random_elev(FILL_NARROW));
    for (k = 0; k < 2; k++) send_sample(random_elev(FILL_NARROW));
    wait_idle(SETTLE);
    write_reg(glmf_pkg::CFG_GRID_COLS, 7'd2);
    for (k = 0; k < 4; k++) send_sample(random_elev(FILL_NARROW));
    wait_idle(SETTLE);
  endtask

  // extreme sizes first, then small random grids, some abandoned midway
  task automatic test_random_grids();
    int fed, grid_no, rows_val, cols_val, cells, n, k;
    fill_t fill;
    fed = 0;
    grid_no = 0;
    while (fed < RANDOM_ITEMS) begin
      case (grid_no)
        0: begin rows_val = 64;  cols_val = 1;  end
        1: begin rows_val = 127; cols_val = 1;  end
        2: begin rows_val = 1;   cols_val = 32; end
        3: begin rows_val = 2;   cols_val = 63; end
        4: begin rows_val = 0;   cols_val = 0;  end
        // bit above the column register width is dropped
        5: begin rows_val = 3;   cols_val = 64 + 5; end
        default: begin
          rows_val = $urandom_range(1, 6);
          cols_val = $urandom_range(1, 10);
        end
      endcase
      if ($urandom_range(1)) begin
        write_reg(glmf_pkg::CFG_GRID_ROWS, glmf_pkg::CFG_DATA_W'(rows_val));
        write_reg(glmf_pkg::CFG_GRID_COLS, glmf_pkg::CFG_DATA_W'(cols_val));
      end else begin
        write_reg(glmf_pkg::CFG_GRID_COLS, glmf_pkg::CFG_DATA_W'(cols_val));
        write_reg(glmf_pkg::CFG_GRID_ROWS, glmf_pkg::CFG_DATA_W'(rows_val));
      end
      cells = rows_in_use() * cols_in_use();
      n = cells;
      if (grid_no >= 6 && $urandom_range(7) == 0) n = $urandom_range(1, cells);
      fill = (grid_no < 6) ? FILL_FULL : fill_t'($urandom_range(0, 2));
      no_idle = (grid_no >= 6 && grid_no < 10);
      for (k = 0; k < n; k++) send_sample(random_elev(fill));
      wait_idle(SETTLE);
      fed += n;
      grid_no++;
    end
    no_idle = 1'b0;
  endtask

  // result sink: random stalls and beat checking
  always @(posedge clk) begin : peak_check
    peak_beat_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (expected_peaks.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected peak beat, expected none, got row %0d col %0d found %0b last %0b",
                 $time, out_ch.peak_row, out_ch.peak_col, out_ch.peak_found,
                 out_ch.frame_last);
      end else begin
        want = expected_peaks.pop_front();
        if (out_ch.peak_row !== want.peak_row || out_ch.peak_col !== want.peak_col ||
            out_ch.peak_found !== want.peak_found ||
            out_ch.frame_last !== want.frame_last) begin
          fail_count++;
          $display("%0t: peak beat mismatch, expected row %0d col %0d found %0b last %0b",
                   $time, want.peak_row, want.peak_col, want.peak_found, want.frame_last);
          $display("%0t:                        got row %0d col %0d found %0b last %0b",
                   $time, out_ch.peak_row, out_ch.peak_col, out_ch.peak_found,
                   out_ch.frame_last);
        end
      end
    end
    out_ch.ready <= (rst_n === 1'b1) && (no_idle || $urandom_range(99) >= IDLE_PCT);
  end

  // run limit
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    fail_count = 0;
    no_idle    = 1'b0;
    foreach (row_buf[i, j]) row_buf[i][j] = '0;
    restart_grid();
    in_ch.valid     <= 1'b0;
    in_ch.elevation <= '0;
    cfg_we          <= 1'b0;
    cfg_index       <= glmf_pkg::CFG_GRID_ROWS;
    cfg_wdata       <= '0;
    rst_n           <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_default_width();
    test_single_cell();
    test_plateau();
    test_end_marker();
    test_restart_on_write();
    test_random_grids();

    wait_idle(TAIL);
    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
